// ----- design/lch_pkg.sv -----
// Shared constants, types and the logarithm table of the log-chroma histogram.
package lch_pkg;

  // Histogram geometry and counter width.
  localparam int BINS       = 256;
  localparam int COUNT_BITS = 17;
  localparam int BIN_BITS   = $clog2(BINS);
  localparam int ADDR_BITS  = 2 * BIN_BITS;
  localparam int MEM_DEPTH  = 1 << ADDR_BITS;

  // Fixed port widths.
  localparam int PIX_BITS       = 8;
  localparam int OUT_COUNT_BITS = 17;
  localparam int CFG_BITS       = 18;
  localparam int CFG_IDX_BITS   = 2;
  localparam int OFFSET_BITS    = 9;
  localparam int LUMA_BITS      = 18;

  // Logarithm table: 64*ln(x) with 16 fraction bits.
  localparam int LOG_BITS  = 25;
  localparam int DIFF_BITS = LOG_BITS + 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_BIN_OFFSET = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LUMA_LOW   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LUMA_HIGH  = 2'd2;

  // Register reset values.
  localparam logic signed [OFFSET_BITS-1:0] BIN_OFFSET_RST = 9'sd91;
  localparam logic [LUMA_BITS-1:0]          LUMA_LOW_RST   = 18'd25500;
  localparam logic [LUMA_BITS-1:0]          LUMA_HIGH_RST  = 18'd229500;

  // Input command codes.
  localparam logic CMD_ACCUMULATE = 1'b0;
  localparam logic CMD_READ_CLEAR = 1'b1;

  typedef logic [255:0][LOG_BITS-1:0] log_tab_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic                 load;
    logic                 calc;
    logic                 bin;
    logic                 mem_rd;
    logic                 commit;
    logic                 clear_wr;
    logic [ADDR_BITS-1:0] clear_addr;
  } lch_ctl_t;

  // Entry 0 is never used, since a zero channel skips the pixel.
  function automatic log_tab_t build_log_tab();
    log_tab_t t;
    t = '0;
    for (int x = 1; x < 256; x++) begin
      t[x] = LOG_BITS'($rtoi(4194304.0 * $ln(real'(x)) + 0.5));
    end
    return t;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();

endpackage

// ----- design/lch_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module lch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/lch_ctrl.sv -----
// Sequencing state machine of the log-chroma histogram, including the clearing sweep.
module lch_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output lch_pkg::lch_ctl_t ctl
);
  import lch_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_BIN,
    ST_READ,
    ST_COMMIT
  } state_t;

  state_t               state;
  logic [ADDR_BITS-1:0] clear_addr;
  logic                 slot_free;

  // The result register can take a new beat when empty or being emptied.
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE);

  always_comb begin
    ctl            = '0;
    ctl.clear_addr = clear_addr;
    unique case (state)
      ST_CLEAR:  ctl.clear_wr = 1'b1;
      ST_IDLE:   ctl.load     = in_valid;
      ST_CALC:   ctl.calc     = 1'b1;
      ST_BIN:    ctl.bin      = 1'b1;
      ST_READ:   ctl.mem_rd   = 1'b1;
      ST_COMMIT: ctl.commit   = slot_free;
      default:   ctl          = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_addr <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (ctl.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clear_addr <= clear_addr + 1'b1;
          if (clear_addr == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_CALC;
          end
        end
        ST_CALC:  state <= ST_BIN;
        ST_BIN:   state <= ST_READ;
        ST_READ:  state <= ST_COMMIT;
        ST_COMMIT: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- design/lch_dp.sv -----
// Datapath: configuration registers, log-chroma binning and the bin counter memory.
module lch_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  lch_pkg::lch_ctl_t                      ctl,
  input  logic                                   cfg_write,
  input  logic [lch_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [lch_pkg::CFG_BITS-1:0]           cfg_data,
  input  logic                                   cmd,
  input  logic [lch_pkg::PIX_BITS-1:0]           red,
  input  logic [lch_pkg::PIX_BITS-1:0]           green,
  input  logic [lch_pkg::PIX_BITS-1:0]           blue,
  input  logic [lch_pkg::PIX_BITS-1:0]           read_u,
  input  logic [lch_pkg::PIX_BITS-1:0]           read_v,
  output logic                                   counted,
  output logic [lch_pkg::PIX_BITS-1:0]           bin_u,
  output logic [lch_pkg::PIX_BITS-1:0]           bin_v,
  output logic [lch_pkg::OUT_COUNT_BITS-1:0]     bin_count
);
  import lch_pkg::*;

  // Configuration registers.
  logic signed [OFFSET_BITS-1:0] bin_offset;
  logic [LUMA_BITS-1:0]          luma_low;
  logic [LUMA_BITS-1:0]          luma_high;

  // Captured input beat.
  logic                cmd_q;
  logic [PIX_BITS-1:0] red_q, green_q, blue_q, ru_q, rv_q;

  // Log stage.
  logic [LUMA_BITS-1:0]        luma;
  logic                        pass_now;
  logic signed [DIFF_BITS-1:0] du, dv;
  logic                        pass_q;
  logic signed [DIFF_BITS-1:0] du_q, dv_q;

  // Bin stage.
  logic [BIN_BITS-1:0]  u_now, v_now;
  logic                 in_range;
  logic [BIN_BITS-1:0]  u_q, v_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic                 touch_q;

  // Memory and update.
  logic                  mem_we;
  logic [ADDR_BITS-1:0]  mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic [COUNT_BITS-1:0] mem_rdata;
  logic [COUNT_BITS-1:0] count_inc;

  // Rounds a Q16 difference to an integer, ties away from zero.
  function automatic logic signed [10:0] round_q16(logic signed [DIFF_BITS-1:0] d);
    logic [DIFF_BITS-1:0] mag;
    logic [9:0]           q;
    mag = d[DIFF_BITS-1] ? DIFF_BITS'(-d) : DIFF_BITS'(d);
    q   = 10'((mag + DIFF_BITS'(32768)) >> 16);
    return d[DIFF_BITS-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  // Adds the bin offset and clamps to the histogram.
  function automatic logic [BIN_BITS-1:0] place_bin(logic signed [DIFF_BITS-1:0] d,
                                                    logic signed [OFFSET_BITS-1:0] off);
    logic signed [10:0] r;
    logic signed [11:0] b;
    r = round_q16(d);
    b = {r[10], r} + {{3{off[OFFSET_BITS-1]}}, off};
    if (b < 0) begin
      return '0;
    end else if (b > $signed(12'(BINS - 1))) begin
      return BIN_BITS'(BINS - 1);
    end
    return BIN_BITS'(b);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_offset <= BIN_OFFSET_RST;
      luma_low   <= LUMA_LOW_RST;
      luma_high  <= LUMA_HIGH_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BIN_OFFSET: bin_offset <= $signed(cfg_data[OFFSET_BITS-1:0]);
        REG_LUMA_LOW:   luma_low   <= cfg_data[LUMA_BITS-1:0];
        REG_LUMA_HIGH:  luma_high  <= cfg_data[LUMA_BITS-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    luma = LUMA_BITS'(red_q) * 18'd299 + LUMA_BITS'(green_q) * 18'd587
         + LUMA_BITS'(blue_q) * 18'd114;
    pass_now = (cmd_q == CMD_ACCUMULATE) && (red_q != '0) && (green_q != '0)
            && (blue_q != '0) && (luma > luma_low) && (luma <= luma_high);
    du = $signed({1'b0, LOG_TAB[green_q]}) - $signed({1'b0, LOG_TAB[red_q]});
    dv = $signed({1'b0, LOG_TAB[green_q]}) - $signed({1'b0, LOG_TAB[blue_q]});
  end

  always_comb begin
    u_now    = place_bin(du_q, bin_offset);
    v_now    = place_bin(dv_q, bin_offset);
    in_range = ({1'b0, ru_q} < 9'(BINS)) && ({1'b0, rv_q} < 9'(BINS));
  end

  always_comb begin
    count_inc = (mem_rdata == '1) ? mem_rdata : mem_rdata + 1'b1;
    if (ctl.clear_wr) begin
      mem_we    = 1'b1;
      mem_waddr = ctl.clear_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = ctl.commit && touch_q;
      mem_waddr = addr_q;
      mem_wdata = (cmd_q == CMD_READ_CLEAR) ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q   <= cmd;
      red_q   <= red;
      green_q <= green;
      blue_q  <= blue;
      ru_q    <= read_u;
      rv_q    <= read_v;
    end
    if (ctl.calc) begin
      pass_q <= pass_now;
      du_q   <= du;
      dv_q   <= dv;
    end
    if (ctl.bin) begin
      u_q <= u_now;
      v_q <= v_now;
      if (cmd_q == CMD_READ_CLEAR) begin
        addr_q  <= {ru_q[BIN_BITS-1:0], rv_q[BIN_BITS-1:0]};
        touch_q <= in_range;
      end else begin
        addr_q  <= {u_now, v_now};
        touch_q <= pass_q;
      end
    end
    if (ctl.commit) begin
      if (cmd_q == CMD_READ_CLEAR) begin
        counted   <= 1'b0;
        bin_u     <= ru_q;
        bin_v     <= rv_q;
        bin_count <= touch_q ? OUT_COUNT_BITS'(mem_rdata) : '0;
      end else if (touch_q) begin
        counted   <= 1'b1;
        bin_u     <= PIX_BITS'(u_q);
        bin_v     <= PIX_BITS'(v_q);
        bin_count <= OUT_COUNT_BITS'(count_inc);
      end else begin
        counted   <= 1'b0;
        bin_u     <= '0;
        bin_v     <= '0;
        bin_count <= '0;
      end
    end
  end

  lch_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(MEM_DEPTH)
  ) u_counts (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (ctl.mem_rd),
    .raddr(addr_q),
    .rdata(mem_rdata)
  );

endmodule

// ----- design/log_chroma_histogram.sv -----
// Top level of the log-chroma histogram: controller, datapath and checks.
//
// Each pixel beat (cmd 0) is masked on zero channels and luma, mapped to a
// (u, v) log-chroma bin through a 256-entry table of 64*ln(x), and that bin's
// saturating counter is incremented; a read beat (cmd 1) returns one bin's
// count and clears it. Every beat gives exactly one result beat. The result
// is registered after the steps luma and table lookup, bin placement,
// memory read and write-back; the write-back waits while the output register
// is full. A new beat is taken only after the previous beat's read-modify-write
// of the counter memory is done, while its result may still wait
// in the output register. After reset the block sweeps the counter memory to
// zero, one entry a cycle, over all 2^(2*ceil(log2 BINS)) entries (65536 at
// 256 bins), and takes no beat until then; configuration writes are taken at
// any time.
module log_chroma_histogram (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [lch_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [lch_pkg::CFG_BITS-1:0]           cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   cmd,
  input  logic [lch_pkg::PIX_BITS-1:0]           red,
  input  logic [lch_pkg::PIX_BITS-1:0]           green,
  input  logic [lch_pkg::PIX_BITS-1:0]           blue,
  input  logic [lch_pkg::PIX_BITS-1:0]           read_u,
  input  logic [lch_pkg::PIX_BITS-1:0]           read_v,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   counted,
  output logic [lch_pkg::PIX_BITS-1:0]           bin_u,
  output logic [lch_pkg::PIX_BITS-1:0]           bin_v,
  output logic [lch_pkg::OUT_COUNT_BITS-1:0]     bin_count
);
  import lch_pkg::*;

  lch_ctl_t ctl;

  lch_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .ctl      (ctl)
  );

  lch_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .red      (red),
    .green    (green),
    .blue     (blue),
    .read_u   (read_u),
    .read_v   (read_v),
    .counted  (counted),
    .bin_u    (bin_u),
    .bin_v    (bin_v),
    .bin_count(bin_count)
  );

`ifndef SYNTHESIS
  // Only one beat is in flight, so acceptance closes the input at once.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a beat is in flight");

  // No beat is taken and no result shown during the clearing sweep.
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    ctl.clear_wr |-> !in_ready && !out_valid)
    else $error("activity during clearing sweep");

  // A write-back never overwrites a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |-> !out_valid || out_ready)
    else $error("result overwritten before it was taken");

  // A result only appears after a write-back.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctl.commit))
    else $error("result without write-back");
`endif

endmodule
